### hdl/lfsa_pkg.sv
// shared types, codes and defaults for the slot allocator
`default_nettype none
package lfsa_pkg;

   localparam int MAX_SPACES_DEFAULT = 16;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;
   localparam int COUNT_W = 5;
   localparam int SLOT_W = 5;
   localparam int KEY_W = 64;
   // wide enough for any slot index up to 511
   localparam int IDX_CMP_W = 9;

   localparam logic [COUNT_W-1:0] SPACES_RESET = 5'd10;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_FREED = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic             is_free;
      logic [KEY_W-1:0] key;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      cmd_type    cmd;
   } cmd_chan_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } bk_state_type;

endpackage
`default_nettype wire

### hdl/lowest_free_slot_allocator.sv
// Slot allocator: an allocate transaction stores its key in the lowest free slot among
// slots 1 to csr_data's last written count and returns that slot or "full"; a free
// transaction releases the lowest occupied slot holding an equal key or reports "not
// found". Requests enter a two-entry command queue; the table executes one command at a
// time, by compare/mask capture, then priority encode and update, and takes no new
// command until the current one completes. Results wait in a two-entry queue, and the
// table stalls only when that queue is full. The count register resets to 10 and is
// taken every cycle outside reset; occupancy clears in the reset cycle, with no sweep.
`default_nettype none
module lowest_free_slot_allocator #(
   parameter int MAX_SPACES = lfsa_pkg::MAX_SPACES_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_push,
   output logic                         req_full,
   input  wire                          req_command,
   input  wire [lfsa_pkg::KEY_W-1:0]    req_vehicle_key,
   output logic                         rsp_empty,
   input  wire                          rsp_pop,
   output logic [1:0]                   rsp_status,
   output logic [lfsa_pkg::SLOT_W-1:0]  rsp_slot,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [lfsa_pkg::COUNT_W-1:0]  csr_data
);

   lfsa_pkg::cmd_chan_type cmd_chan;
   lfsa_pkg::rsp_type rsp_item;
   logic cmd_pop, rsp_push, rsp_space;

   assign csr_ready = !reset;

   lfsa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_vehicle_key (req_vehicle_key),
      .cmd_out         (cmd_chan),
      .cmd_pop         (cmd_pop)
   );

   lfsa_back #(
      .MAX_SPACES (MAX_SPACES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .cmd_in    (cmd_chan),
      .cmd_pop   (cmd_pop),
      .rsp_space (rsp_space),
      .rsp_push  (rsp_push),
      .rsp_out   (rsp_item)
   );

   lfsa_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .rsp_push   (rsp_push),
      .rsp_in     (rsp_item),
      .rsp_space  (rsp_space),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   // a result is never offered to a full result queue
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_space)
      else $error("result pushed into full queue");

   // the table takes a command only when one is waiting
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_chan.valid)
      else $error("command popped from empty queue");

   // every command taken yields its result in the following cycle
   a_pop_then_push: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_push && !cmd_pop)
      else $error("command did not complete in two cycles");

   // failed commands carry no slot number
   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_push && (rsp_item.status == lfsa_pkg::ST_FULL
                   || rsp_item.status == lfsa_pkg::ST_NOT_FOUND) |-> rsp_item.slot == '0)
      else $error("slot number on a failed command");

endmodule
`default_nettype wire

### hdl/lfsa_front.sv
// front end: takes requests, classifies the command and queues it for the table
`default_nettype none
module lfsa_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  wire                      req_command,
   input  wire [lfsa_pkg::KEY_W-1:0] req_vehicle_key,
   output lfsa_pkg::cmd_chan_type   cmd_out,
   input  wire                      cmd_pop
);

   localparam int PTR_W = $clog2(lfsa_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(lfsa_pkg::CMD_DEPTH + 1);

   lfsa_pkg::cmd_type entry_ff [lfsa_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;
   lfsa_pkg::cmd_type new_cmd;

   assign req_full = (count_ff == CNT_W'(lfsa_pkg::CMD_DEPTH)) || reset;
   assign do_push = req_push && !req_full;
   assign do_pop = cmd_pop && (count_ff != '0);

   always_comb begin
      new_cmd.is_free = (req_command == lfsa_pkg::CMD_FREE);
      new_cmd.key = req_vehicle_key;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lfsa_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lfsa_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_comb begin
      cmd_out.valid = (count_ff != '0);
      cmd_out.cmd = entry_ff[rd_ptr_ff];
   end

endmodule
`default_nettype wire

### hdl/lfsa_back.sv
// back end: slot table with occupancy, key compare and lowest-slot priority encode
`default_nettype none
module lfsa_back #(
   parameter int MAX_SPACES = lfsa_pkg::MAX_SPACES_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write,
   input  wire [lfsa_pkg::COUNT_W-1:0]    csr_value,
   input  lfsa_pkg::cmd_chan_type         cmd_in,
   output logic                           cmd_pop,
   input  wire                            rsp_space,
   output logic                           rsp_push,
   output lfsa_pkg::rsp_type              rsp_out
);

   localparam int IDX_W = (MAX_SPACES > 1) ? $clog2(MAX_SPACES) : 1;

   lfsa_pkg::bk_state_type state_ff, state_in;
   logic [lfsa_pkg::COUNT_W-1:0] spaces_ff;
   logic [MAX_SPACES-1:0] occ_ff, occ_in;
   logic [MAX_SPACES-1:0] vec_ff, vec_in;
   lfsa_pkg::cmd_type cur_ff, cur_in;
   logic [lfsa_pkg::KEY_W-1:0] key_ff [MAX_SPACES];

   logic [MAX_SPACES-1:0] usable, key_eq;
   logic [IDX_W-1:0] hit_idx;
   logic hit, key_we;
   logic [IDX_W:0] slot_num;

   // per-slot compare and count mask, each at a fixed slot
   for (genvar i = 0; i < MAX_SPACES; i++) begin : g_slot
      localparam logic [lfsa_pkg::IDX_CMP_W-1:0] SLOT_IDX = lfsa_pkg::IDX_CMP_W'(i);
      assign usable[i] = SLOT_IDX < lfsa_pkg::IDX_CMP_W'(spaces_ff);
      assign key_eq[i] = (key_ff[i] == cmd_in.cmd.key);
   end

   // lowest set bit wins
   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = MAX_SPACES - 1; i >= 0; i--) begin
         if (vec_ff[i]) begin
            hit = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign slot_num = {1'b0, hit_idx} + 1'b1;

   always_comb begin
      state_in = state_ff;
      cmd_pop = 1'b0;
      rsp_push = 1'b0;
      vec_in = vec_ff;
      cur_in = cur_ff;
      occ_in = occ_ff;
      key_we = 1'b0;
      rsp_out.status = lfsa_pkg::ST_FULL;
      rsp_out.slot = '0;
      case (state_ff)
         lfsa_pkg::BK_IDLE: begin
            if (cmd_in.valid && rsp_space) begin
               cmd_pop = 1'b1;
               cur_in = cmd_in.cmd;
               vec_in = cmd_in.cmd.is_free ? (occ_ff & key_eq) : (~occ_ff & usable);
               state_in = lfsa_pkg::BK_EXEC;
            end
         end
         lfsa_pkg::BK_EXEC: begin
            rsp_push = 1'b1;
            if (cur_ff.is_free) begin
               rsp_out.status = hit ? lfsa_pkg::ST_FREED : lfsa_pkg::ST_NOT_FOUND;
               if (hit) begin
                  occ_in[hit_idx] = 1'b0;
               end
            end else begin
               rsp_out.status = hit ? lfsa_pkg::ST_ALLOCATED : lfsa_pkg::ST_FULL;
               if (hit) begin
                  occ_in[hit_idx] = 1'b1;
                  key_we = 1'b1;
               end
            end
            rsp_out.slot = hit ? lfsa_pkg::SLOT_W'(slot_num) : '0;
            state_in = lfsa_pkg::BK_IDLE;
         end
         default: begin
            state_in = lfsa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfsa_pkg::BK_IDLE;
         occ_ff <= '0;
         spaces_ff <= lfsa_pkg::SPACES_RESET;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         if (csr_write) begin
            spaces_ff <= csr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      cur_ff <= cur_in;
      if (key_we) begin
         key_ff[hit_idx] <= cur_ff.key;
      end
   end

endmodule
`default_nettype wire

### hdl/lfsa_rsp_queue.sv
// result queue between the table and the response side
`default_nettype none
module lfsa_rsp_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        rsp_push,
   input  lfsa_pkg::rsp_type          rsp_in,
   output logic                       rsp_space,
   output logic                       rsp_empty,
   input  wire                        rsp_pop,
   output logic [1:0]                 rsp_status,
   output logic [lfsa_pkg::SLOT_W-1:0] rsp_slot
);

   localparam int PTR_W = $clog2(lfsa_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(lfsa_pkg::RSP_DEPTH + 1);

   lfsa_pkg::rsp_type entry_ff [lfsa_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;
   lfsa_pkg::rsp_type head;

   assign rsp_space = (count_ff != CNT_W'(lfsa_pkg::RSP_DEPTH));
   assign rsp_empty = (count_ff == '0) || reset;
   assign do_push = rsp_push && rsp_space;
   assign do_pop = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lfsa_pkg::RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lfsa_pkg::RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign rsp_status = head.status;
   assign rsp_slot = head.slot;

endmodule
`default_nettype wire
